[src/assert_macros.svh]
// assertion helpers used by the grid_min_path_sum_traceback rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[src/gmps_pkg.sv]
package gmps_pkg;

   // grid bounds
   localparam int MAX_ROWS = 16;
   localparam int MAX_COLS = 16;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int MOVES    = MAX_ROWS + MAX_COLS - 2;
   localparam int MV_DEPTH = (MOVES > 0) ? MOVES : 1;

   // field widths
   localparam int COST_W    = 16;
   localparam int SUM_W     = 21;
   localparam int SIZE_W    = 5;
   localparam int CSR_IDX_W = 2;
   localparam int RSP_DATA_W = ((SUM_W + 1 + 7) / 8) * 8;

   // derived index and counter widths
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MVN_W = $clog2(MV_DEPTH + 1);
   localparam int MV_W  = (MV_DEPTH > 1) ? $clog2(MV_DEPTH) : 1;

   // size register reset values
   localparam logic [SIZE_W-1:0] RESET_ROWS = SIZE_W'(16);
   localparam logic [SIZE_W-1:0] RESET_COLS = SIZE_W'(16);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = CSR_IDX_W'(1);

   // result kinds and move codes
   localparam logic KIND_SUM   = 1'b0;
   localparam logic KIND_MOVE  = 1'b1;
   localparam logic MOVE_RIGHT = 1'b0;
   localparam logic MOVE_DOWN  = 1'b1;

   typedef logic signed [COST_W-1:0] cost_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

endpackage

[src/gmps_alu.sv]
module gmps_alu (
   input  gmps_pkg::sum_type alu_a,
   input  gmps_pkg::sum_type alu_b,
   output logic              alu_le,
   output gmps_pkg::sum_type alu_sum
);
   import gmps_pkg::*;

   logic signed [SUM_W:0] wide_sum;

   // compare used for the min step and for the traceback choice
   assign alu_le = (alu_a <= alu_b);

   // add with saturation to the sum width
   assign wide_sum = {alu_a[SUM_W-1], alu_a} + {alu_b[SUM_W-1], alu_b};

   always_comb begin
      if (wide_sum[SUM_W] != wide_sum[SUM_W-1]) begin
         alu_sum = wide_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         alu_sum = wide_sum[SUM_W-1:0];
      end
   end

endmodule

[src/grid_min_path_sum_traceback.sv]
// channel   | dir | handshake         | payload
// req_      | in  | tvalid / tready   | tdata[15:0] cell_cost
// rsp_      | out | tvalid / tready   | tdata[20:0] min_sum, [21] move_dir; tuser item_kind;
//           |     |                   | tlast last_item
// csr_      | in  | we                | index 0 grid_rows, 1 grid_cols; wdata[4:0]
//
// a cell that does not complete the grid is taken back to back
// the completing cell starts the fill: each cell steps through read, compare and add on the shared alu,
// then traceback: an edge move in the check state, an interior move through check, up, left, compare (one sum port)
// results then leave one word per cycle while rsp_tready is high
// reset clears control and sets both sizes to 16; grid and sum memories keep no reset
// req_tready stays low from the completing cell until the last result word is registered
`include "assert_macros.svh"

module grid_min_path_sum_traceback (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gmps_pkg::COST_W-1:0]         req_tdata,   // [15:0] cell_cost
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gmps_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [20:0] min_sum, [21] move_dir
   output logic                                rsp_tuser,   // [0] item_kind
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [gmps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gmps_pkg::SIZE_W-1:0]         csr_wdata
);
   import gmps_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_FILL_RD   = 4'd1;
   localparam logic [3:0] ST_FILL_CMP  = 4'd2;
   localparam logic [3:0] ST_FILL_ADD  = 4'd3;
   localparam logic [3:0] ST_TR_CHK    = 4'd4;
   localparam logic [3:0] ST_TR_UP     = 4'd5;
   localparam logic [3:0] ST_TR_LEFT   = 4'd6;
   localparam logic [3:0] ST_TR_CMP    = 4'd7;
   localparam logic [3:0] ST_EMIT_SUM  = 4'd8;
   localparam logic [3:0] ST_EMIT_MOVE = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [SIZE_W-1:0] rows_ff, cols_ff;
   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic [ROW_W-1:0]  a_ff, a_in, p1_ff, p1_in;
   logic [COL_W-1:0]  b_ff, b_in, p2_ff, p2_in;
   logic [IDX_W-1:0]  i_ff, i_in, idx_ff, idx_in;
   logic [MVN_W-1:0]  n_ff, n_in;
   sum_type           best_ff, best_in, prev_ff, prev_in, final_ff, final_in, up_ff, up_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic              rsp_kind_ff, rsp_last_ff;
   logic              mvbuf_ff [MV_DEPTH];

   // memories
   cost_type          cost_mem [CELLS];
   sum_type           sum_mem  [CELLS];
   cost_type          cost_rd_ff;
   sum_type           sum_rd_ff;
   logic [IDX_W-1:0]  sum_rd_addr;

   // sizes and derived bounds
   logic [SIZE_W-1:0] rows_eff, cols_eff;
   logic [CNT_W-1:0]  total;
   logic [ROW_W-1:0]  rows_m1;
   logic [COL_W-1:0]  cols_m1;
   logic [IDX_W-1:0]  cols_idx;

   // shared unit
   sum_type           alu_a, alu_b, alu_sum;
   logic              alu_le;

   logic              req_take, tr_take, tr_down, out_free, out_load;
   logic              out_kind, out_dir, out_last;
   sum_type           out_sum, fill_best;

   gmps_alu u_alu (
      .alu_a   (alu_a),
      .alu_b   (alu_b),
      .alu_le  (alu_le),
      .alu_sum (alu_sum)
   );

   // size clamp to 1..max
   assign rows_eff = (rows_ff == '0) ? SIZE_W'(1) :
                     (rows_ff > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff == '0) ? SIZE_W'(1) :
                     (cols_ff > MAX_COLS) ? SIZE_W'(MAX_COLS) : cols_ff;
   assign total    = CNT_W'(rows_eff) * CNT_W'(cols_eff);
   assign rows_m1  = ROW_W'(rows_eff - 1'b1);
   assign cols_m1  = COL_W'(cols_eff - 1'b1);
   assign cols_idx = IDX_W'(cols_eff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // alu operand select
   always_comb begin
      alu_a = sum_rd_ff;
      alu_b = prev_ff;
      unique case (state_ff)
         ST_FILL_ADD: begin
            alu_a = best_ff;
            alu_b = sum_type'(cost_rd_ff);
         end
         ST_TR_CMP: begin
            alu_a = up_ff;
            alu_b = sum_rd_ff;
         end
         default: begin
            alu_a = sum_rd_ff;
            alu_b = prev_ff;
         end
      endcase
   end

   // best predecessor, ties go to the cell above
   always_comb begin
      if (a_ff == '0 && b_ff == '0) begin
         fill_best = '0;
      end else if (a_ff == '0) begin
         fill_best = prev_ff;
      end else if (b_ff == '0) begin
         fill_best = sum_rd_ff;
      end else begin
         fill_best = alu_le ? sum_rd_ff : prev_ff;
      end
   end

   // traceback move decision
   assign tr_take = (state_ff == ST_TR_CMP) ||
                    (state_ff == ST_TR_CHK && !(p1_ff == '0 && p2_ff == '0) &&
                     (p1_ff == '0 || p2_ff == '0));
   assign tr_down = (state_ff == ST_TR_CMP) ? alu_le : (p2_ff == '0);

   // sum memory read address
   always_comb begin
      unique case (state_ff)
         ST_FILL_RD: sum_rd_addr = i_ff - cols_idx;
         ST_TR_UP:   sum_rd_addr = idx_ff - cols_idx;
         ST_TR_LEFT: sum_rd_addr = idx_ff - 1'b1;
         default:    sum_rd_addr = i_ff;
      endcase
   end

   // result word build
   always_comb begin
      out_load = 1'b0;
      out_kind = KIND_SUM;
      out_sum  = '0;
      out_dir  = MOVE_RIGHT;
      out_last = 1'b0;
      unique case (state_ff)
         ST_EMIT_SUM: begin
            out_load = out_free;
            out_sum  = final_ff;
            out_last = (n_ff == '0);
         end
         ST_EMIT_MOVE: begin
            out_load = out_free;
            out_kind = KIND_MOVE;
            out_dir  = mvbuf_ff[MV_W'(n_ff - 1'b1)];
            out_last = (n_ff == MVN_W'(1));
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      i_in          = i_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      best_in       = best_ff;
      prev_in       = prev_ff;
      final_in      = final_ff;
      up_in         = up_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (CNT_W'(load_count_ff + 1'b1) >= total) begin
                  load_count_in = '0;
                  a_in          = '0;
                  b_in          = '0;
                  i_in          = '0;
                  state_in      = ST_FILL_RD;
               end else begin
                  load_count_in = CNT_W'(load_count_ff + 1'b1);
               end
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_CMP;
         end
         ST_FILL_CMP: begin
            best_in  = fill_best;
            state_in = ST_FILL_ADD;
         end
         ST_FILL_ADD: begin
            prev_in = alu_sum;
            i_in    = i_ff + 1'b1;
            if (b_ff == cols_m1) begin
               if (a_ff == rows_m1) begin
                  final_in = alu_sum;
                  p1_in    = rows_m1;
                  p2_in    = cols_m1;
                  idx_in   = i_ff;
                  n_in     = '0;
                  state_in = ST_TR_CHK;
               end else begin
                  a_in     = a_ff + 1'b1;
                  b_in     = '0;
                  state_in = ST_FILL_RD;
               end
            end else begin
               b_in     = b_ff + 1'b1;
               state_in = ST_FILL_RD;
            end
         end
         ST_TR_CHK: begin
            if (p1_ff == '0 && p2_ff == '0) begin
               state_in = ST_EMIT_SUM;
            end else if (p1_ff != '0 && p2_ff != '0) begin
               state_in = ST_TR_UP;
            end
         end
         ST_TR_UP: begin
            state_in = ST_TR_LEFT;
         end
         ST_TR_LEFT: begin
            up_in    = sum_rd_ff;
            state_in = ST_TR_CMP;
         end
         ST_TR_CMP: begin
            state_in = ST_TR_CHK;
         end
         ST_EMIT_SUM: begin
            if (out_free) begin
               state_in = (n_ff == '0) ? ST_IDLE : ST_EMIT_MOVE;
            end
         end
         ST_EMIT_MOVE: begin
            if (out_free) begin
               n_in = n_ff - 1'b1;
               if (n_ff == MVN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step one move back along the path
      if (tr_take) begin
         n_in = n_ff + 1'b1;
         if (tr_down) begin
            p1_in  = p1_ff - 1'b1;
            idx_in = idx_ff - cols_idx;
         end else begin
            p2_in  = p2_ff - 1'b1;
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   // output valid next value
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rows_ff       <= RESET_ROWS;
         cols_ff       <= RESET_COLS;
         load_count_ff <= '0;
         a_ff          <= '0;
         b_ff          <= '0;
         i_ff          <= '0;
         p1_ff         <= '0;
         p2_ff         <= '0;
         idx_ff        <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         i_ff          <= i_in;
         p1_ff         <= p1_in;
         p2_ff         <= p2_in;
         idx_ff        <= idx_in;
         n_ff          <= n_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we && csr_index == CSR_GRID_ROWS) begin
            rows_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_GRID_COLS) begin
            cols_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      prev_ff  <= prev_in;
      final_ff <= final_in;
      up_ff    <= up_in;
      if (tr_take) begin
         mvbuf_ff[n_ff[MV_W-1:0]] <= tr_down;
      end
      if (out_load) begin
         rsp_data_ff <= RSP_DATA_W'({out_dir, out_sum});
         rsp_kind_ff <= out_kind;
         rsp_last_ff <= out_last;
      end
   end

   // cost memory: written on load, read during fill
   always_ff @(posedge clock) begin
      if (req_take && load_count_ff < CELLS) begin
         cost_mem[load_count_ff[IDX_W-1:0]] <= req_tdata;
      end
      cost_rd_ff <= cost_mem[i_ff];
   end

   // sum memory: written during fill, read during fill and traceback
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL_ADD) begin
         sum_mem[i_ff] <= alu_sum;
      end
      sum_rd_ff <= sum_mem[sum_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLK(a_move_pending, (state_ff == ST_EMIT_MOVE) |-> (n_ff != '0), "move word with empty buffer")
   `ASSERT_CLK(a_trace_bound, (state_ff == ST_TR_CHK && n_ff == MVN_W'(MOVES)) |-> (p1_ff == '0 && p2_ff == '0), "traceback longer than path")
   `ASSERT_CLK(a_last_idle, (out_load && out_last) |=> (state_ff == ST_IDLE), "last word without return to idle")
   `ASSERT_NEVER(a_load_bound, load_count_ff >= CNT_W'(CELLS), "load count past grid storage")

endmodule

[dv/tb_grid_min_path_sum_traceback.sv]
module tb_grid_min_path_sum_traceback;
   import gmps_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES   = 64;
   localparam int PHASE_CELLS    = 15;
   localparam int SUM_HI         = 2 ** (SUM_W - 1) - 1;
   localparam int SUM_LO         = -(2 ** (SUM_W - 1));

   // indexes past the register list, the block ignores them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   localparam cost_type COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
   localparam cost_type COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

   // one result word as the block sends it
   typedef struct packed {
      logic    kind;
      sum_type sum;
      logic    dir;
      logic    last;
   } grid_result_type;

   typedef enum logic [1:0] {STEP_CSR, STEP_CELL, STEP_CELL_TYPED} step_kind_type;

   typedef struct packed {
      step_kind_type          kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [SIZE_W-1:0]      val;
      cost_type               cost;
      sum_type                sum;
   } directed_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [COST_W-1:0]       req_tdata = '0;     // [15:0] cell_cost
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;          // [20:0] min_sum, [21] move_dir
   logic                    rsp_tuser;          // [0] item_kind
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [SIZE_W-1:0]       csr_wdata = '0;

   grid_min_path_sum_traceback u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow of the block: sizes, loaded costs, fill count
   logic [SIZE_W-1:0] shadow_rows = RESET_ROWS;
   logic [SIZE_W-1:0] shadow_cols = RESET_COLS;
   cost_type          shadow_costs [CELLS];
   int unsigned       shadow_loaded = 0;

   grid_result_type fresh_words [$];
   grid_result_type expected_words [$];
   directed_step_type directed_steps [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int quiet_cycles       = 0;
   grid_result_type got_word, want_word;

   function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
      if (v == 0) return 1;
      if (int'(v) > hi) return hi;
      return int'(v);
   endfunction

   // take one cell; when the grid completes, fill sums and trace the path
   function automatic void load_cell_and_route(input cost_type cost);
      int rows, cols, total, r, c, i, best, up, left, pr, pc, n, k;
      int path_sums [CELLS];
      logic trace [MOVES+1];
      rows = clamp_size(shadow_rows, MAX_ROWS);
      cols = clamp_size(shadow_cols, MAX_COLS);
      total = rows * cols;
      fresh_words.delete();
      if (shadow_loaded < CELLS) shadow_costs[shadow_loaded] = cost;
      shadow_loaded++;
      if (shadow_loaded < total) return;
      shadow_loaded = 0;

      // fill, ties taken from above
      for (r = 0; r < rows; r++) begin
         for (c = 0; c < cols; c++) begin
            i = r * cols + c;
            if (r == 0 && c == 0) best = 0;
            else if (r == 0) best = path_sums[i-1];
            else if (c == 0) best = path_sums[i-cols];
            else begin
               up = path_sums[i-cols];
               left = path_sums[i-1];
               best = (up > left) ? left : up;
            end
            best = best + int'(shadow_costs[i]);
            if (best > SUM_HI) best = SUM_HI;
            if (best < SUM_LO) best = SUM_LO;
            path_sums[i] = best;
         end
      end

      // walk back from the bottom-right corner, equal sums go down
      pr = rows - 1;
      pc = cols - 1;
      n = 0;
      while ((pr != 0 || pc != 0) && n < MOVES + 1) begin
         if (pc == 0) trace[n] = MOVE_DOWN;
         else if (pr == 0) trace[n] = MOVE_RIGHT;
         else trace[n] = (path_sums[(pr-1)*cols+pc] <= path_sums[pr*cols+pc-1])
                         ? MOVE_DOWN : MOVE_RIGHT;
         if (trace[n] == MOVE_DOWN) pr--;
         else pc--;
         n++;
      end

      fresh_words.push_back('{KIND_SUM, sum_type'(path_sums[total-1]), MOVE_RIGHT, n == 0});
      for (k = n - 1; k >= 0; k--)
         fresh_words.push_back('{KIND_MOVE, sum_type'(0), trace[k], k == 0});
   endfunction

   function automatic cost_type draw_cost(input int unsigned flavor);
      case (flavor)
         0: return cost_type'($urandom);
         1: return cost_type'(int'($urandom_range(0, 4)) - 2);
         2: return $urandom_range(0, 1) ? COST_MAX : COST_MIN;
         default: return COST_MAX - cost_type'($urandom_range(0, 1000));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] extreme_size();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return SIZE_W'(1);
         2: return SIZE_W'(16);
         3: return '1;
         default: return SIZE_W'($urandom_range(17, 30));
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic send_cell(input cost_type cost, input bit typed, input sum_type typed_sum);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cost;
      do @(posedge clock); while (!req_tready);
      load_cell_and_route(cost);
      if (typed) begin
         if (fresh_words.size() != 0)
            expected_words.push_back('{KIND_SUM, typed_sum, MOVE_RIGHT, 1'b1});
      end else begin
         foreach (fresh_words[j]) expected_words.push_back(fresh_words[j]);
      end
      @(negedge clock);
   endtask

   // register write once the block has drained and settled
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_GRID_ROWS) shadow_rows = val;
      else if (idx == CSR_GRID_COLS) shadow_cols = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic void log_mismatch(input string tag, input grid_result_type want,
                                        input grid_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected kind %0d sum %0d dir %0d last %0d, %s %0d sum %0d dir %0d last %0d",
                  tag, want.kind, want.sum, want.dir, want.last, "got kind",
                  got.kind, got.sum, got.dir, got.last);
   endfunction

   // receiver backpressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // result check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_word = '{rsp_tuser, sum_type'(rsp_tdata[SUM_W-1:0]), rsp_tdata[SUM_W], rsp_tlast};
            if (expected_words.size() == 0) begin
               log_mismatch("unexpected word", '0, got_word);
            end else begin
               want_word = expected_words.pop_front();
               if (got_word !== want_word) log_mismatch("word mismatch", want_word, got_word);
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("grid_min_path_sum_traceback regression: fail");
            $finish;
         end
      end
   end

   initial begin
      int phase_cells, total, n, flavor;
      logic [SIZE_W-1:0] r, c;
      int send_plan [4];
      int stall_plan [4];
      send_plan = '{0, 69, 0, 38};
      stall_plan = '{0, 0, 69, 38};

      // single cell grids: extremes and zero-as-one sizes
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(1), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(1), '0, '0});
      directed_steps.push_back('{STEP_CELL_TYPED, '0, '0, COST_MAX, sum_type'(COST_MAX)});
      directed_steps.push_back('{STEP_CELL_TYPED, '0, '0, COST_MIN, sum_type'(COST_MIN)});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(0), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(0), '0, '0});
      directed_steps.push_back('{STEP_CELL_TYPED, '0, '0, cost_type'(-1), sum_type'(-1)});
      // 2x2 with equal sums at the corner
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(2), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(2), '0, '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(0), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(1), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(1), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(0), '0});
      // single row, then single column
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(1), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(3), '0, '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(3), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(-2), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(7), '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(3), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(1), '0, '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(-5), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(4), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(2), '0});
      // writes past the register list change nothing
      directed_steps.push_back('{STEP_CSR, CSR_SPARE_LO, '1, '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_SPARE_HI, '0, '0, '0});
      // grid shrinks under a partial load, next cell completes it
      directed_steps.push_back('{STEP_CSR, CSR_GRID_ROWS, SIZE_W'(2), '0, '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(3), '0, '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(1), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(2), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(3), '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(4), '0});
      directed_steps.push_back('{STEP_CSR, CSR_GRID_COLS, SIZE_W'(2), '0, '0});
      directed_steps.push_back('{STEP_CELL, '0, '0, cost_type'(9), '0});

      // reset
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no idling
      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_CSR: begin
               write_csr(directed_steps[i].idx, directed_steps[i].val);
            end
            STEP_CELL: begin
               send_cell(directed_steps[i].cost, 1'b0, '0);
            end
            default: begin
               send_cell(directed_steps[i].cost, 1'b1, directed_steps[i].sum);
            end
         endcase
      end

      // random grids over the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct = send_plan[ph];
         receiver_stall_pct = stall_plan[ph];
         if (ph == 0) begin
            // one full-size grid for the longest path
            write_csr(CSR_GRID_ROWS, SIZE_W'(MAX_ROWS));
            write_csr(CSR_GRID_COLS, SIZE_W'(MAX_COLS));
            repeat (CELLS) send_cell(draw_cost($urandom_range(0, 3)), 1'b0, '0);
         end
         phase_cells = 0;
         while (phase_cells < PHASE_CELLS) begin
            case ($urandom_range(0, 9))
               0: begin
                  r = extreme_size();
                  c = SIZE_W'($urandom_range(1, 3));
               end
               1: begin
                  r = SIZE_W'($urandom_range(1, 3));
                  c = extreme_size();
               end
               default: begin
                  r = SIZE_W'($urandom_range(1, 5));
                  c = SIZE_W'($urandom_range(1, 5));
               end
            endcase
            write_csr(CSR_GRID_ROWS, r);
            write_csr(CSR_GRID_COLS, c);
            if ($urandom_range(0, 15) == 0)
               write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, SIZE_W'($urandom));
            total = clamp_size(r, MAX_ROWS) * clamp_size(c, MAX_COLS);
            n = total * $urandom_range(1, 2);
            // now and then a shorter load, which may leave the grid partly loaded
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, total);
            flavor = $urandom_range(0, 3);
            repeat (n) send_cell(draw_cost(flavor), 1'b0, '0);
            phase_cells += n;
         end
      end

      // drain
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("grid_min_path_sum_traceback regression: pass");
      end else begin
         $display("grid_min_path_sum_traceback regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/gmps_pkg.sv
src/gmps_alu.sv
src/grid_min_path_sum_traceback.sv
dv/tb_grid_min_path_sum_traceback.sv
